/* rtl/m4t_pkg.sv */
package m4t_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_IDENTITY  = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_SCALE     = 3'd2,
    OP_TRANSPOSE = 3'd3,
    OP_LOAD_ROW  = 3'd4,
    OP_COMMIT    = 3'd5,
    OP_XFORM     = 3'd6,
    OP_READ_ROW  = 3'd7
  } op_t;

  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         row_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic signed [31:0] out_d;
  } out_item_t;

  // control from sequencer to the lanes
  typedef struct packed {
    logic start;   // new dot product operands presented
    logic scale;   // single product only (element 0 of lane)
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/m4t_dot_lane.sv */
// one dot-product lane: four multiplies, registered, then a sum and saturation
module m4t_dot_lane #(
  parameter int unsigned FRAC_BITS = m4t_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  m4t_pkg::lane_ctl_t  ctl,
  input  logic signed [31:0]  a [4],
  input  logic signed [31:0]  b [4],
  output logic signed [31:0]  dot
);
  import m4t_pkg::*;

  logic signed [63:0] prod_r [4];
  logic               scale_r;
  logic signed [65:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= (64'(a[k]) * 64'(b[k])) >>> FRAC_BITS;
      end
      scale_r <= ctl.scale;
    end
  end

  always_comb begin
    if (scale_r) begin
      sum = 66'(prod_r[0]);
    end else begin
      sum = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]) + 66'(prod_r[3]);
    end
  end

  assign dot = sat32(sum);

endmodule

/* rtl/mat4_transform_unit.sv */
// 4x4 Q16.16 transform matrix unit. Each transfer on the in_ channel carries one
// operation; transform vector and read row each give one transfer on the out_
// channel, the other operations give none. Four dot-product lanes work side by
// side, one per matrix row or result column. A vector transform steps through
// accept, multiply and sum/saturate into the output register; scale takes the
// same multiply and sum steps through the lanes; a commit takes accept, then
// one multiply and one sum step of the four lanes per product row; the other
// operations take accept and multiply. A transform or read row result then holds
// the input off until its transfer. The lane multiply/sum pass sets the rate.
// Only one item is in work at a time; in_stall is high while an item is in work
// or a result waits.
module mat4_transform_unit #(
  parameter int unsigned FRAC_BITS = m4t_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  m4t_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output m4t_pkg::out_item_t out_data
);
  import m4t_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] mat_r [16];
  logic signed [31:0] pre_r [16];
  logic signed [31:0] tmp_r [16];   // commit product under construction
  in_item_t           item_r;
  logic [1:0]         row_r;        // commit product row in work
  out_item_t          out_r;

  lane_ctl_t          ctl;
  logic signed [31:0] la [4][4];
  logic signed [31:0] lb [4][4];
  logic signed [31:0] dot [4];
  logic signed [31:0] vec [4];

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  assign vec[0] = item_r.value_a;
  assign vec[1] = item_r.value_b;
  assign vec[2] = item_r.value_c;
  assign vec[3] = item_r.value_d;

  // lane operands: transform uses matrix rows against the vector, commit uses
  // premultiplier row row_r against matrix columns, scale uses lane i diagonal
  always_comb begin
    ctl.start = (state_r == ST_MUL);
    ctl.scale = (item_r.mode == OP_SCALE);
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        la[i][k] = mat_r[i*4+k];
        lb[i][k] = vec[k];
        if (item_r.mode == OP_COMMIT) begin
          la[i][k] = pre_r[{row_r, 2'(k)}];
          lb[i][k] = mat_r[k*4+i];
        end else if (item_r.mode == OP_SCALE) begin
          la[i][k] = mat_r[i*5];
          lb[i][k] = vec[i];
        end
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    m4t_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .ctl (ctl),
      .a   (la[g]),
      .b   (lb[g]),
      .dot (dot[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL: begin
        if (item_r.mode == OP_XFORM || item_r.mode == OP_SCALE ||
            item_r.mode == OP_COMMIT) begin
          state_nxt = ST_SUM;
        end else if (item_r.mode == OP_READ_ROW) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (item_r.mode == OP_XFORM) begin
          state_nxt = ST_OUT;
        end else if (item_r.mode == OP_COMMIT && row_r != 2'd3) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // matrix and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= ((i & 3) == (i >> 2)) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
        pre_r[i] <= 32'sd0;
      end
      row_r <= 2'd0;
    end else begin
      if (accept) begin
        item_r <= in_data;
        row_r  <= 2'd0;
      end
      if (state_r == ST_MUL) begin
        unique case (item_r.mode)
          OP_IDENTITY: begin
            for (int i = 0; i < 16; i++) begin
              mat_r[i] <= ((i & 3) == (i >> 2)) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
          end
          OP_TRANSLATE: begin
            for (int i = 0; i < 3; i++) begin
              mat_r[i*4+3] <= sat32(66'(mat_r[i*4+3]) + 66'(vec[i]));
            end
          end
          OP_TRANSPOSE: begin
            for (int i = 0; i < 4; i++) begin
              for (int j = 0; j < 4; j++) begin
                mat_r[i*4+j] <= mat_r[j*4+i];
              end
            end
          end
          OP_LOAD_ROW: begin
            for (int j = 0; j < 4; j++) begin
              pre_r[{item_r.row_index, 2'(j)}] <= vec[j];
            end
          end
          OP_READ_ROW: begin
            out_r.result_kind <= KIND_ROW;
            out_r.out_a <= mat_r[{item_r.row_index, 2'd0}];
            out_r.out_b <= mat_r[{item_r.row_index, 2'd1}];
            out_r.out_c <= mat_r[{item_r.row_index, 2'd2}];
            out_r.out_d <= mat_r[{item_r.row_index, 2'd3}];
          end
          default: ;
        endcase
      end
      if (state_r == ST_SUM) begin
        unique case (item_r.mode)
          OP_XFORM: begin
            out_r.result_kind <= KIND_VECTOR;
            out_r.out_a <= dot[0];
            out_r.out_b <= dot[1];
            out_r.out_c <= dot[2];
            out_r.out_d <= dot[3];
          end
          OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
              mat_r[i*5] <= dot[i];
            end
          end
          OP_COMMIT: begin
            // lanes hold one product row; the last row replaces the matrix
            for (int j = 0; j < 4; j++) begin
              tmp_r[{row_r, 2'(j)}] <= dot[j];
            end
            if (row_r == 2'd3) begin
              for (int i = 0; i < 12; i++) begin
                mat_r[i] <= tmp_r[i];
              end
              for (int j = 0; j < 4; j++) begin
                mat_r[12+j] <= dot[j];
              end
            end
            row_r <= row_r + 2'd1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/m4t_checker.sv */
module m4t_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input m4t_pkg::in_item_t in_data,
  input logic              out_valid,
  input logic              out_stall,
  input m4t_pkg::out_item_t out_data
);
  import m4t_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new transfer while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // no result follows the multiply step of an identity operation
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == OP_IDENTITY |=> ##1 !out_valid)
    else $error("result after update operation");

  // a read row transfer shows its row result after the multiply state
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == OP_READ_ROW |=> ##1
      out_valid && out_data.result_kind == KIND_ROW)
    else $error("read row result missing");

endmodule

bind mat4_transform_unit m4t_checker u_m4t_checker (.*);
